FILE: hw/rtl/lpfr_pkg.sv
// package for the length-prefixed frame receiver
// holds phase type, result status codes and parameter defaults
// no dependencies
package lpfr_pkg;

    // default width of the frame byte counters
    localparam int LENGTH_BITS_DEF = 16;

    // bytes in the little-endian length header
    localparam int HEADER_BYTES = 4;

    // reset value of the length limit register
    localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

    // register word indexes
    localparam logic [0:0] REG_MAX_LEN = 1'b0;

    // result status codes
    localparam logic [2:0] ST_HEADER  = 3'd0;
    localparam logic [2:0] ST_PAYLOAD = 3'd1;
    localparam logic [2:0] ST_REJECT  = 3'd2;
    localparam logic [2:0] ST_DISCARD = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    // receiver phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_INVALID = 2'd2
    } t_phase;

endpackage

FILE: hw/rtl/length_prefixed_frame_receiver.sv
// an accepted item's result is written to the output register in the next cycle
// throughput: one item per cycle unless a waiting result is not taken; the phase/counter
//   update and the header length compare sit between the input port and the result register
// an item is taken while a result waits as long as the result is taken in that cycle
// reset (synchronous, active low) returns to awaiting a header, limit 4096
// depends on lpfr_pkg
module length_prefixed_frame_receiver
    import lpfr_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_frame_offset,
    output logic        o_frame_last,
    output logic [15:0] o_frame_length,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // largest value the byte counters can hold
    localparam logic [32:0] COUNT_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

    // state
    t_phase                 r_phase, n_phase;
    logic [23:0]            r_hdr, n_hdr;
    logic [LENGTH_BITS-1:0] r_pos, n_pos;
    logic [LENGTH_BITS-1:0] r_exp, n_exp;
    logic [15:0]            r_max;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [7:0]  r_byte;
    logic [15:0] r_offset;
    logic        r_last;
    logic [15:0] r_length;

    // per-item combinational result
    logic [2:0]             c_status;
    logic [15:0]            c_offset;
    logic                   c_last;
    logic [15:0]            c_length;
    logic [1:0]             hpos;
    logic [31:0]            declared;
    logic [LENGTH_BITS-1:0] pos_inc;
    logic [31:0]            pos_ext;
    logic [31:0]            exp_ext;
    logic                   accept;
    logic                   cfg_wr;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2:2] == REG_MAX_LEN) ? {16'd0, r_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_LEN_RESET;
        end else if (cfg_wr && paddr[2:2] == REG_MAX_LEN) begin
            r_max <= pwdata[15:0];
        end
    end

    // helpers for the next-state logic
    assign hpos     = r_pos[1:0];
    assign declared = {i_data_byte, r_hdr};
    assign pos_inc  = r_pos + LENGTH_BITS'(1);
    assign pos_ext  = 32'(r_pos);
    assign exp_ext  = 32'(r_exp);

    // next state and result for one item
    always_comb begin
        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_pos    = r_pos;
        n_exp    = r_exp;
        c_status = ST_HEADER;
        c_offset = 16'd0;
        c_last   = 1'b0;
        c_length = 16'd0;
        if (i_command) begin
            // clear back to idle
            n_phase  = PH_HEADER;
            n_hdr    = '0;
            n_pos    = '0;
            n_exp    = '0;
            c_status = ST_CLEARED;
        end else begin
            unique case (r_phase)
                PH_INVALID: begin
                    c_status = ST_DISCARD;
                end
                PH_PAYLOAD: begin
                    c_status = ST_PAYLOAD;
                    c_offset = pos_ext[15:0];
                    c_length = exp_ext[15:0];
                    n_pos    = pos_inc;
                    if (pos_inc == r_exp) begin
                        c_last  = 1'b1;
                        n_phase = PH_HEADER;
                        n_hdr   = '0;
                        n_pos   = '0;
                        n_exp   = '0;
                    end
                end
                default: begin
                    // header byte; the unused phase code behaves the same
                    c_offset = {14'd0, hpos};
                    n_pos    = LENGTH_BITS'(hpos) + LENGTH_BITS'(1);
                    case (hpos)
                        2'd0: n_hdr[7:0]   = i_data_byte;
                        2'd1: n_hdr[15:8]  = i_data_byte;
                        2'd2: n_hdr[23:16] = i_data_byte;
                        default: begin
                            // last header byte: check the declared length
                            if (declared < 32'(HEADER_BYTES) || declared > {16'd0, r_max}
                                    || {1'b0, declared} > COUNT_MAX) begin
                                c_status = ST_REJECT;
                                n_phase  = PH_INVALID;
                            end else if (declared == 32'(HEADER_BYTES)) begin
                                c_length = declared[15:0];
                                c_last   = 1'b1;
                                n_phase  = PH_HEADER;
                                n_hdr    = '0;
                                n_pos    = '0;
                                n_exp    = '0;
                            end else begin
                                c_length = declared[15:0];
                                n_exp    = LENGTH_BITS'(declared);
                                n_hdr    = '0;
                                n_phase  = PH_PAYLOAD;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hdr   <= '0;
            r_pos   <= '0;
            r_exp   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_pos   <= n_pos;
            r_exp   <= n_exp;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= c_status;
            r_byte   <= i_data_byte;
            r_offset <= c_offset;
            r_last   <= c_last;
            r_length <= c_length;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_payload_byte = r_byte;
    assign o_frame_offset = r_offset;
    assign o_frame_last   = r_last;
    assign o_frame_length = r_length;

    // frame completion is only flagged on header or payload items
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> (r_status == ST_HEADER || r_status == ST_PAYLOAD))
        else $error("frame_last on non-frame status");

    // a rejected length reports no frame length
    a_reject_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_REJECT) |-> (r_length == 16'd0 && !r_last))
        else $error("rejected item carries a length");

    // a clear item leaves the receiver idle
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command) |=> (r_phase == PH_HEADER && r_pos == '0 && r_exp == '0))
        else $error("clear did not return to idle");

    // a frame in payload always expects more than the header
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_exp > LENGTH_BITS'(HEADER_BYTES)))
        else $error("payload phase with short length");

endmodule
